### hw/rtl/lsau_pkg.sv
// Shared types and constants for the lidar sweep azimuth unwrapper.
`default_nettype none
package lsau_pkg;
	localparam int unsigned AngW = 18;
	localparam int unsigned AccW = 36;
	localparam int unsigned CxW = 40;
	localparam int unsigned TableLen = 24;
	localparam logic signed [AngW-1:0] AngHalfPi = 18'sd4096;
	localparam logic signed [AngW-1:0] AngPi = 18'sd8192;
	localparam logic signed [AngW-1:0] AngThreeHalfPi = 18'sd12288;
	localparam logic signed [AngW-1:0] AngTwoPi = 18'sd16384;
	localparam logic signed [AngW-1:0] AngThreePi = 18'sd24576;
	localparam logic signed [AccW-1:0] FineHalfPi = 36'sd8388608;
	localparam logic [1:0] CmdFirst = 2'd0;
	localparam logic [1:0] CmdLast = 2'd1;
	localparam logic [1:0] CmdPoint = 2'd2;
	localparam logic [1:0] CmdUnused = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RANGE, ST_CORDIC, ST_UNWRAP, ST_DIVIDE, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic range_step;
		logic cordic_init;
		logic cordic_step;
		logic unwrap;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic drop;
		logic cordic_done;
		logic div_done;
	} stat_t;

	// atan(2^-i) in 2^24 units per pi
	function automatic logic signed [AccW-1:0] atan_fine(input logic [4:0] i);
		logic signed [AccW-1:0] r;
		begin
			unique case (i)
				5'd0: r = 36'sd4194304; 5'd1: r = 36'sd2476042; 5'd2: r = 36'sd1308273;
				5'd3: r = 36'sd664100; 5'd4: r = 36'sd333339; 5'd5: r = 36'sd166832;
				5'd6: r = 36'sd83436; 5'd7: r = 36'sd41721; 5'd8: r = 36'sd20861;
				5'd9: r = 36'sd10430; 5'd10: r = 36'sd5215; 5'd11: r = 36'sd2608;
				5'd12: r = 36'sd1304; 5'd13: r = 36'sd652; 5'd14: r = 36'sd326;
				5'd15: r = 36'sd163; 5'd16: r = 36'sd81; 5'd17: r = 36'sd41;
				5'd18: r = 36'sd20; 5'd19: r = 36'sd10; 5'd20: r = 36'sd5;
				5'd21: r = 36'sd3; 5'd22: r = 36'sd1; 5'd23: r = 36'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

### hw/rtl/lsau_ctrl.sv
// Controller state machine sequencing range check, CORDIC, unwrap and divide.
`default_nettype none
module lsau_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire lsau_pkg::stat_t stat,
	output lsau_pkg::cmd_t cmd
);
	lsau_pkg::state_t state_q, state_d;
	logic [1:0] rcnt_q;

	// state register and range-step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsau_pkg::ST_IDLE;
			rcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lsau_pkg::ST_RANGE) rcnt_q <= rcnt_q + 2'd1;
			else rcnt_q <= '0;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lsau_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = lsau_pkg::ST_RANGE;
				end
			end
			lsau_pkg::ST_RANGE: begin
				cmd.range_step = 1'b1;
				if (rcnt_q == 2'd3) begin
					if (stat.command == lsau_pkg::CmdFirst ||
					    stat.command == lsau_pkg::CmdLast ||
					    (stat.command == lsau_pkg::CmdPoint && !stat.drop)) begin
						cmd.cordic_init = 1'b1;
						state_d = lsau_pkg::ST_CORDIC;
					end else begin
						state_d = lsau_pkg::ST_IDLE;
					end
				end
			end
			lsau_pkg::ST_CORDIC: begin
				if (stat.cordic_done) begin
					cmd.unwrap = 1'b1;
					state_d = (stat.command == lsau_pkg::CmdPoint) ?
						lsau_pkg::ST_UNWRAP : lsau_pkg::ST_IDLE;
				end else begin
					cmd.cordic_step = 1'b1;
				end
			end
			lsau_pkg::ST_UNWRAP: begin
				cmd.div_init = 1'b1;
				state_d = lsau_pkg::ST_DIVIDE;
			end
			lsau_pkg::ST_DIVIDE: begin
				if (stat.div_done) begin
					cmd.out_load = 1'b1;
					state_d = lsau_pkg::ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			lsau_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = lsau_pkg::ST_IDLE;
			end
			default: state_d = lsau_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/lsau_datapath.sv
// Datapath: range check, iterative CORDIC, unwrap state and restoring divider.
`default_nettype none
module lsau_datapath #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lsau_pkg::cmd_t cmd,
	output lsau_pkg::stat_t stat,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata,
	input wire logic [1:0] command,
	input wire logic signed [31:0] point_x,
	input wire logic signed [31:0] point_y,
	input wire logic signed [31:0] point_z,
	input wire logic [7:0] point_intensity,
	input wire logic coords_valid,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [7:0] out_intensity,
	output logic signed [17:0] sweep_fraction
);
	localparam int unsigned Steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam logic [4:0] LastStep = 5'(Steps - 1);

	logic [1:0] cmd_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [7:0] inten_q;
	logic valid_q;
	logic [31:0] min_r2_q;
	logic signed [17:0] start_q, end_q;
	logic half_q;

	// range accumulation, one axis square per step
	logic [65:0] r2_q;
	logic [1:0] rsel_q;
	logic signed [31:0] sq_in;
	logic [63:0] sq;

	// CORDIC registers
	logic signed [lsau_pkg::CxW-1:0] cx_q, cy_q;
	logic signed [lsau_pkg::AccW-1:0] cz_q;
	logic [4:0] it_q;
	logic zero_q, cdone_q;

	// divider registers
	logic [35:0] rem_q;
	logic [35:0] quo_q;
	logic [19:0] dvs_q;
	logic [35:0] dnd_q;
	logic [5:0] dcnt_q;
	logic nneg_q, dneg_q, den0_q;
	logic signed [19:0] num_q;

	logic signed [17:0] az;
	logic signed [lsau_pkg::AccW-1:0] zr;
	logic signed [17:0] ori_a, ori_b, ecand;
	logic signed [19:0] num_c, den_c;
	logic [36:0] rtry;
	logic signed [37:0] qs;
	logic signed [17:0] frac;

	assign stat.command = cmd_q;
	assign stat.drop = !valid_q || (r2_q < {34'd0, min_r2_q});
	assign stat.cordic_done = cdone_q;
	assign stat.div_done = (dcnt_q == 6'd0);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_r2_q <= 32'd429497;
		else if (cfg_we) min_r2_q <= cfg_wdata;
	end

	always_comb begin
		unique case (rsel_q)
			2'd0: sq_in = px_q;
			2'd1: sq_in = py_q;
			default: sq_in = pz_q;
		endcase
		sq = 64'($signed(sq_in) * $signed(sq_in));
	end

	// rounded, negated azimuth
	always_comb begin
		zr = (cz_q + 36'sd1024) >>> 11;
		az = zero_q ? 18'sd0 : -18'(zr);
	end

	// unwrap of the point azimuth
	always_comb begin
		ori_a = az;
		if (!half_q) begin
			if (az < start_q - lsau_pkg::AngHalfPi) ori_a = az + lsau_pkg::AngTwoPi;
			else if (az > start_q + lsau_pkg::AngThreeHalfPi)
				ori_a = az - lsau_pkg::AngTwoPi;
		end else begin
			ori_b = az + lsau_pkg::AngTwoPi;
			ori_a = ori_b;
			if (ori_b < end_q - lsau_pkg::AngThreeHalfPi)
				ori_a = ori_b + lsau_pkg::AngTwoPi;
			else if (ori_b > end_q + lsau_pkg::AngHalfPi)
				ori_a = ori_b - lsau_pkg::AngTwoPi;
		end
		ori_b = az + lsau_pkg::AngTwoPi;
		ecand = ori_b;
		if (ori_b - start_q > lsau_pkg::AngThreePi) ecand = ori_b - lsau_pkg::AngTwoPi;
		else if (ori_b - start_q < lsau_pkg::AngPi) ecand = ori_b + lsau_pkg::AngTwoPi;
		num_c = 20'(ori_a) - 20'(start_q);
		den_c = 20'(end_q) - 20'(start_q);
	end

	assign rtry = {rem_q, dnd_q[35]} - {17'd0, dvs_q};

	// signed quotient and saturation
	always_comb begin
		qs = (nneg_q ^ dneg_q) ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});
		if (den0_q) begin
			if (num_q > 0) frac = 18'sd131071;
			else if (num_q < 0) frac = -18'sd131072;
			else frac = 18'sd0;
		end else if (qs > 38'sd131071) frac = 18'sd131071;
		else if (qs < -38'sd131072) frac = -18'sd131072;
		else frac = 18'(qs);
	end

	// request capture and range sum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			px_q <= point_x; py_q <= point_y; pz_q <= point_z;
			inten_q <= point_intensity;
			valid_q <= coords_valid;
			r2_q <= '0;
			rsel_q <= '0;
		end else if (cmd.range_step && rsel_q != 2'd3) begin
			r2_q <= r2_q + {2'b0, sq};
			rsel_q <= rsel_q + 2'd1;
		end
	end

	// CORDIC iterations
	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			zero_q <= (px_q == 0) && (py_q == 0);
			it_q <= '0;
			cdone_q <= 1'b0;
			if (px_q < 0) begin
				if (py_q >= 0) begin
					cx_q <= 40'(py_q); cy_q <= -40'(px_q); cz_q <= lsau_pkg::FineHalfPi;
				end else begin
					cx_q <= -40'(py_q); cy_q <= 40'(px_q); cz_q <= -lsau_pkg::FineHalfPi;
				end
			end else begin
				cx_q <= 40'(px_q); cy_q <= 40'(py_q); cz_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + (cy_q >>> it_q);
				cy_q <= cy_q - (cx_q >>> it_q);
				cz_q <= cz_q + lsau_pkg::atan_fine(it_q);
			end else begin
				cx_q <= cx_q - (cy_q >>> it_q);
				cy_q <= cy_q + (cx_q >>> it_q);
				cz_q <= cz_q - lsau_pkg::atan_fine(it_q);
			end
			it_q <= it_q + 5'd1;
			cdone_q <= (it_q == LastStep);
		end
	end

	// sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q <= lsau_pkg::AngTwoPi;
			half_q <= 1'b0;
		end else if (cmd.unwrap) begin
			unique case (cmd_q)
				lsau_pkg::CmdFirst: start_q <= az;
				lsau_pkg::CmdLast: begin
					end_q <= ecand;
					half_q <= 1'b0;
				end
				default: if (!half_q && (ori_a - start_q > lsau_pkg::AngPi)) half_q <= 1'b1;
			endcase
		end
	end

	// unsigned restoring divider of |num|*65536 by |den|
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_init) dcnt_q <= 6'd36;
		else if (cmd.div_step) dcnt_q <= dcnt_q - 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.unwrap) begin
			num_q <= num_c;
			nneg_q <= num_c[19];
			dneg_q <= den_c[19];
			den0_q <= (den_c == 0);
			dnd_q <= {(num_c[19] ? 16'(-num_c) : 16'(num_c)), 20'd0} >> 4;
			dvs_q <= den_c[19] ? 20'(-den_c) : 20'(den_c);
		end
		if (cmd.div_init) begin
			dnd_q <= {(nneg_q ? 20'(-num_q) : 20'(num_q)), 16'd0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dnd_q <= dnd_q << 1;
			if (!rtry[36]) begin
				rem_q <= rtry[35:0];
				quo_q <= {quo_q[34:0], 1'b1};
			end else begin
				rem_q <= {rem_q[34:0], dnd_q[35]};
				quo_q <= {quo_q[34:0], 1'b0};
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x <= py_q;
			out_y <= pz_q;
			out_z <= px_q;
			out_intensity <= inten_q;
			sweep_fraction <= frac;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/lidar_sweep_azimuth_unwrap.sv
// Top level of the lidar sweep azimuth unwrapper.
// One request at a time. A point request runs through the range check, CORDIC_STEPS
// (at most 24) CORDIC iterations, the unwrap and the bit-serial restoring divider;
// first and last point requests end after the CORDIC and dropped points after the range
// check. min_range_squared may be written only while idle.
`default_nettype none
module lidar_sweep_azimuth_unwrap #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] command,
	input wire logic signed [31:0] point_x,
	input wire logic signed [31:0] point_y,
	input wire logic signed [31:0] point_z,
	input wire logic [7:0] point_intensity,
	input wire logic coords_valid,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [7:0] out_intensity,
	output logic signed [17:0] sweep_fraction
);
	lsau_pkg::cmd_t cmd;
	lsau_pkg::stat_t stat;

	lsau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	lsau_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .command(command),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.point_intensity(point_intensity), .coords_valid(coords_valid),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_intensity(out_intensity), .sweep_fraction(sweep_fraction)
	);
endmodule
`default_nettype wire
